// ===== hw/rtl/keypad_code_lock_core_assert.svh =====
// Assertion macros for the keypad code lock RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef KEYPAD_CODE_LOCK_CORE_ASSERT_SVH
`define KEYPAD_CODE_LOCK_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define KCL_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("keypad code lock check failed");
`define KCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("keypad code lock check failed");
`else
`define KCL_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define KCL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/kcl_pkg.sv =====
`default_nettype none
package kcl_pkg;

	localparam int CODE_BYTES    = 6;
	localparam int MAX_ENTRY_DEF = 6;

	typedef enum logic [1:0] {
		PH_USER = 2'd0,
		PH_PASS = 2'd1,
		PH_CTRL = 2'd2
	} phase_t;

	typedef enum logic [3:0] {
		EV_IGNORED  = 4'd0,
		EV_TAKEN    = 4'd1,
		EV_DELETED  = 4'd2,
		EV_NAME_BAD = 4'd3,
		EV_NAME_OK  = 4'd4,
		EV_PASS_BAD = 4'd5,
		EV_PASS_OK  = 4'd6,
		EV_LOCKED   = 4'd7,
		EV_EXIT     = 4'd8
	} ev_t;

	typedef enum logic [2:0] {
		CFG_USER_CODE   = 3'd0,
		CFG_USER_LENGTH = 3'd1,
		CFG_PASS_CODE   = 3'd2,
		CFG_PASS_LENGTH = 3'd3,
		CFG_MAX_TRIALS  = 3'd4
	} cfg_idx_t;

	localparam logic [7:0] KEY_E     = 8'h45;
	localparam logic [7:0] KEY_C     = 8'h43;
	localparam logic [7:0] KEY_5     = 8'h35;
	localparam logic [7:0] KEY_6     = 8'h36;
	localparam logic [7:0] KEY_8     = 8'h38;
	localparam logic [7:0] KEY_9     = 8'h39;
	localparam logic [7:0] KEY_PLUS  = 8'h2B;
	localparam logic [7:0] KEY_MINUS = 8'h2D;
	localparam logic [7:0] KEY_SLASH = 8'h2F;
	localparam logic [7:0] KEY_STAR  = 8'h2A;
	localparam logic [7:0] KEY_0     = 8'h30;

	localparam logic [47:0] USER_CODE_RST   = 48'd241343411505;
	localparam logic [2:0]  USER_LENGTH_RST = 3'd5;
	localparam logic [47:0] PASS_CODE_RST   = 48'd245755491121;
	localparam logic [2:0]  PASS_LENGTH_RST = 3'd5;
	localparam logic [7:0]  MAX_TRIALS_RST  = 8'd3;

	typedef struct packed {
		logic [47:0] user_code;
		logic [2:0]  user_length;
		logic [47:0] pass_code;
		logic [2:0]  pass_length;
		logic [7:0]  max_trials;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		ev_t         ev;
		logic [7:0]  failures;
		logic        fan;
		logic        light;
		logic        alarm;
	} lock_stat_t;

	function automatic logic is_entry_key(input logic [7:0] k);
		return (k >= KEY_0 && k <= KEY_9) || k == KEY_PLUS || k == KEY_MINUS ||
			k == KEY_SLASH || k == KEY_STAR;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/kcl_key_if.sv =====
`default_nettype none
interface kcl_key_if;
	logic       valid;
	logic       ready;
	logic [7:0] key;

	modport source (output valid, output key, input ready);
	modport sink (input valid, input key, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/kcl_res_if.sv =====
`default_nettype none
interface kcl_res_if #(
	parameter int CNT_W = 3
);
	logic             valid;
	logic             ready;
	logic [1:0]       phase;
	logic [3:0]       event_res;
	logic [CNT_W-1:0] entry_count;
	logic [7:0]       failures;
	logic             fan_on;
	logic             light_on;
	logic             alarm_on;

	modport source (output valid, output phase, output event_res, output entry_count,
		output failures, output fan_on, output light_on, output alarm_on, input ready);
	modport sink (input valid, input phase, input event_res, input entry_count,
		input failures, input fan_on, input light_on, input alarm_on, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/kcl_cfg_if.sv =====
`default_nettype none
interface kcl_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [47:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/kcl_cfg_regs.sv =====
`default_nettype none
module kcl_cfg_regs (
	input  wire logic    clk,
	input  wire logic    arst_n,
	kcl_cfg_if.sink      cfg,
	output kcl_pkg::cfg_t regs
);
	import kcl_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.user_code   <= USER_CODE_RST;
			regs_q.user_length <= USER_LENGTH_RST;
			regs_q.pass_code   <= PASS_CODE_RST;
			regs_q.pass_length <= PASS_LENGTH_RST;
			regs_q.max_trials  <= MAX_TRIALS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_USER_CODE: begin
					regs_q.user_code <= cfg.data;
				end
				CFG_USER_LENGTH: begin
					regs_q.user_length <= cfg.data[2:0];
				end
				CFG_PASS_CODE: begin
					regs_q.pass_code <= cfg.data;
				end
				CFG_PASS_LENGTH: begin
					regs_q.pass_length <= cfg.data[2:0];
				end
				CFG_MAX_TRIALS: begin
					regs_q.max_trials <= cfg.data[7:0];
				end
				default: begin
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/kcl_lock_fsm.sv =====
`default_nettype none
`include "keypad_code_lock_core_assert.svh"
module kcl_lock_fsm #(
	parameter int MAX_ENTRY = kcl_pkg::MAX_ENTRY_DEF,
	parameter int LEN_W     = $clog2(MAX_ENTRY + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic [7:0]    key,
	input  wire kcl_pkg::cfg_t cfg,
	output kcl_pkg::lock_stat_t stat,
	output logic [LEN_W-1:0]   entry_count
);
	import kcl_pkg::*;

	localparam int IDX_W = (MAX_ENTRY > 1) ? $clog2(MAX_ENTRY) : 1;
	localparam int CMP_N = (MAX_ENTRY < CODE_BYTES) ? MAX_ENTRY : CODE_BYTES;
	localparam int CMP_W = (LEN_W > 3) ? LEN_W : 3;

	phase_t           phase_q;
	logic [LEN_W-1:0] entry_len_q;
	logic [7:0]       fail_q;
	logic             fan_q;
	logic             light_q;
	logic             alarm_q;
	logic [7:0]       buf_q [MAX_ENTRY];

	phase_t           phase_d;
	ev_t              ev_d;
	logic [LEN_W-1:0] entry_len_d;
	logic [7:0]       fail_d;
	logic             fan_d;
	logic             light_d;
	logic             alarm_d;

	logic             edit_wr;
	ev_t              edit_ev;
	logic [LEN_W-1:0] edit_len;
	logic             user_ok;
	logic             pass_ok;
	logic [7:0]       fail_inc;
	logic [CMP_N-1:0] user_byte_ok;
	logic [CMP_N-1:0] pass_byte_ok;

	// A check passes only when the lengths agree exactly and every held character matches.
	always_comb begin
		for (int i = 0; i < CMP_N; i++) begin
			user_byte_ok[i] = (i >= int'(entry_len_q)) || (buf_q[i] == cfg.user_code[8*i +: 8]);
			pass_byte_ok[i] = (i >= int'(entry_len_q)) || (buf_q[i] == cfg.pass_code[8*i +: 8]);
		end
		user_ok = (cfg.user_length != 3'd0) && (cfg.user_length <= 3'(CODE_BYTES)) &&
			(CMP_W'(cfg.user_length) == CMP_W'(entry_len_q)) && (&user_byte_ok);
		pass_ok = (cfg.pass_length != 3'd0) && (cfg.pass_length <= 3'(CODE_BYTES)) &&
			(CMP_W'(cfg.pass_length) == CMP_W'(entry_len_q)) && (&pass_byte_ok);
	end

	always_comb begin
		edit_wr  = 1'b0;
		edit_ev  = EV_IGNORED;
		edit_len = entry_len_q;
		if (is_entry_key(key)) begin
			if (entry_len_q < LEN_W'(MAX_ENTRY)) begin
				edit_wr  = 1'b1;
				edit_len = entry_len_q + LEN_W'(1);
				edit_ev  = EV_TAKEN;
			end
		end else if (key == KEY_C && entry_len_q != '0) begin
			edit_len = entry_len_q - LEN_W'(1);
			edit_ev  = EV_DELETED;
		end
	end

	assign fail_inc = (fail_q != 8'hFF) ? fail_q + 8'd1 : fail_q;

	always_comb begin
		phase_d     = phase_q;
		ev_d        = EV_IGNORED;
		entry_len_d = entry_len_q;
		fail_d      = fail_q;
		fan_d       = fan_q;
		light_d     = light_q;
		alarm_d     = alarm_q;
		case (phase_q)
			PH_CTRL: begin
				case (key)
					KEY_5: begin
						fan_d = 1'b1;
						ev_d  = EV_TAKEN;
					end
					KEY_6: begin
						fan_d = 1'b0;
						ev_d  = EV_TAKEN;
					end
					KEY_8: begin
						light_d = 1'b1;
						ev_d    = EV_TAKEN;
					end
					KEY_9: begin
						light_d = 1'b0;
						ev_d    = EV_TAKEN;
					end
					KEY_C: begin
						fail_d      = '0;
						entry_len_d = '0;
						phase_d     = PH_USER;
						ev_d        = EV_EXIT;
					end
					default: begin
					end
				endcase
			end
			PH_PASS: begin
				if (key == KEY_E) begin
					entry_len_d = '0;
					if (pass_ok) begin
						phase_d = PH_CTRL;
						ev_d    = EV_PASS_OK;
					end else begin
						fail_d = fail_inc;
						if (fail_inc >= cfg.max_trials) begin
							alarm_d = 1'b1;
							phase_d = PH_USER;
							ev_d    = EV_LOCKED;
						end else begin
							ev_d = EV_PASS_BAD;
						end
					end
				end else begin
					entry_len_d = edit_len;
					ev_d        = edit_ev;
				end
			end
			default: begin
				phase_d = PH_USER;
				if (key == KEY_E) begin
					entry_len_d = '0;
					if (!user_ok) begin
						ev_d = EV_NAME_BAD;
					end else if (alarm_q) begin
						ev_d = EV_LOCKED;
					end else begin
						phase_d = PH_PASS;
						ev_d    = EV_NAME_OK;
					end
				end else begin
					entry_len_d = edit_len;
					ev_d        = edit_ev;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_USER;
			entry_len_q <= '0;
			fail_q      <= '0;
			fan_q       <= 1'b0;
			light_q     <= 1'b0;
			alarm_q     <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_d;
			entry_len_q <= entry_len_d;
			fail_q      <= fail_d;
			fan_q       <= fan_d;
			light_q     <= light_d;
			alarm_q     <= alarm_d;
		end
	end

	// Only entries below the fill count are ever compared, so the buffer needs no reset.
	always_ff @(posedge clk) begin
		if (step && edit_wr && (phase_q != PH_CTRL) && (key != KEY_E)) begin
			buf_q[entry_len_q[IDX_W-1:0]] <= key;
		end
	end

	assign stat.phase    = phase_d;
	assign stat.ev       = ev_d;
	assign stat.failures = fail_d;
	assign stat.fan      = fan_d;
	assign stat.light    = light_d;
	assign stat.alarm    = alarm_d;
	assign entry_count   = entry_len_d;

	`KCL_ASSERT_ALWAYS(a_len_in_range, clk, arst_n, entry_len_q <= LEN_W'(MAX_ENTRY))
	`KCL_ASSERT_NEXT(a_alarm_latched, clk, arst_n, alarm_q, alarm_q)
	`KCL_ASSERT_NEXT(a_no_pass_after_lockout, clk, arst_n, alarm_q && phase_q != PH_PASS, phase_q != PH_PASS)
	`KCL_ASSERT_NEXT(a_exit_clears, clk, arst_n, step && phase_q == PH_CTRL && key == KEY_C, entry_len_q == '0 && fail_q == '0 && phase_q == PH_USER)
endmodule
`default_nettype wire

// ===== hw/rtl/keypad_code_lock_core.sv =====
// Keypad code lock: one keypad character per word on the keys channel, one status word per
// character on the results channel. A new character can be taken every cycle as long as results
// are taken. Each one is held in the input register, and its result is captured in the result
// register on the edge that moves it on; the lock state and entry buffer are updated on that
// same edge, while both code compares are combinational on the held character.
// Configuration writes are always accepted and take effect at once; write them only while no
// character is in flight.
`default_nettype none
module keypad_code_lock_core #(
	parameter int MAX_ENTRY = kcl_pkg::MAX_ENTRY_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	kcl_key_if.sink   keys,
	kcl_res_if.source results,
	kcl_cfg_if.sink   cfg
);
	import kcl_pkg::*;

	localparam int LEN_W = $clog2(MAX_ENTRY + 1);

	cfg_t             cfg_regs;
	lock_stat_t       stat;
	logic [LEN_W-1:0] entry_count;

	logic             key_vld_s1;
	logic [7:0]       key_s1;
	logic             res_vld_s2;
	lock_stat_t       stat_s2;
	logic [LEN_W-1:0] count_s2;

	logic             advance;
	logic             step;

	assign advance    = !res_vld_s2 || results.ready;
	assign keys.ready = !key_vld_s1 || advance;
	assign step       = key_vld_s1 && advance;

	kcl_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (cfg_regs)
	);

	kcl_lock_fsm #(
		.MAX_ENTRY (MAX_ENTRY),
		.LEN_W     (LEN_W)
	) u_fsm (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.key         (key_s1),
		.cfg         (cfg_regs),
		.stat        (stat),
		.entry_count (entry_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_vld_s1 <= 1'b0;
			res_vld_s2 <= 1'b0;
		end else begin
			if (keys.ready) begin
				key_vld_s1 <= keys.valid;
			end
			if (advance) begin
				res_vld_s2 <= key_vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (keys.valid && keys.ready) begin
			key_s1 <= keys.key;
		end
		if (step) begin
			stat_s2  <= stat;
			count_s2 <= entry_count;
		end
	end

	assign results.valid       = res_vld_s2;
	assign results.phase       = 2'(stat_s2.phase);
	assign results.event_res   = 4'(stat_s2.ev);
	assign results.entry_count = count_s2;
	assign results.failures    = stat_s2.failures;
	assign results.fan_on      = stat_s2.fan;
	assign results.light_on    = stat_s2.light;
	assign results.alarm_on    = stat_s2.alarm;
endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
module tb;
	import kcl_pkg::*;

	typedef struct packed {
		phase_t     phase;
		ev_t        ev;
		logic [2:0] count;
		logic [7:0] failures;
		logic       fan;
		logic       light;
		logic       alarm;
	} lock_status_t;

	logic clk = 1'b0;
	logic arst_n;

	kcl_key_if key_if ();
	kcl_res_if res_if ();
	kcl_cfg_if cfg_if ();

	keypad_code_lock_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.keys    (key_if),
		.results (res_if),
		.cfg     (cfg_if)
	);

	always #5 clk = ~clk;

	logic [47:0] user_code_m;
	logic [2:0]  user_len_m;
	logic [47:0] pass_code_m;
	logic [2:0]  pass_len_m;
	logic [7:0]  trials_m;

	phase_t      lock_phase;
	logic [7:0]  entry_chars [MAX_ENTRY_DEF];
	int unsigned entry_len;
	logic [7:0]  fail_cnt;
	logic        fan_m;
	logic        light_m;
	logic        alarm_m;

	lock_status_t pending_status [$];
	lock_status_t want;
	int unsigned  mismatches = 0;
	int unsigned  keys_sent = 0;
	int unsigned  hold_cycles = 0;
	bit           tx_calm = 1'b0;
	bit           rx_calm = 1'b0;
	bit           lockout_ok = 1'b0;

	function automatic bit is_code_char(input logic [7:0] k);
		return k inside {[KEY_0:KEY_9], KEY_PLUS, KEY_MINUS, KEY_SLASH, KEY_STAR};
	endfunction

	function automatic bit entry_matches(input logic [47:0] code, input logic [2:0] len);
		if (len == 3'd0 || len > CODE_BYTES || entry_len != len)
			return 1'b0;
		for (int i = 0; i < entry_len; i++)
			if (code[8*i +: 8] != entry_chars[i])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic ev_t edit_entry(input logic [7:0] k);
		if (is_code_char(k)) begin
			if (entry_len < MAX_ENTRY_DEF) begin
				entry_chars[entry_len] = k;
				entry_len++;
				return EV_TAKEN;
			end
			return EV_IGNORED;
		end
		if (k == KEY_C && entry_len > 0) begin
			entry_len--;
			return EV_DELETED;
		end
		return EV_IGNORED;
	endfunction

	function automatic lock_status_t step_lock(input logic [7:0] k);
		ev_t ev;
		bit  ok;
		ev = EV_IGNORED;
		case (lock_phase)
			PH_CTRL: begin
				case (k)
					KEY_5: begin
						fan_m = 1'b1;
						ev = EV_TAKEN;
					end
					KEY_6: begin
						fan_m = 1'b0;
						ev = EV_TAKEN;
					end
					KEY_8: begin
						light_m = 1'b1;
						ev = EV_TAKEN;
					end
					KEY_9: begin
						light_m = 1'b0;
						ev = EV_TAKEN;
					end
					KEY_C: begin
						fail_cnt = 8'd0;
						entry_len = 0;
						lock_phase = PH_USER;
						ev = EV_EXIT;
					end
					default: ;
				endcase
			end
			PH_PASS: begin
				if (k == KEY_E) begin
					ok = entry_matches(pass_code_m, pass_len_m);
					entry_len = 0;
					if (ok) begin
						lock_phase = PH_CTRL;
						ev = EV_PASS_OK;
					end else begin
						if (fail_cnt != 8'hFF)
							fail_cnt++;
						if (fail_cnt >= trials_m) begin
							alarm_m = 1'b1;
							lock_phase = PH_USER;
							ev = EV_LOCKED;
						end else begin
							ev = EV_PASS_BAD;
						end
					end
				end else begin
					ev = edit_entry(k);
				end
			end
			default: begin
				lock_phase = PH_USER;
				if (k == KEY_E) begin
					ok = entry_matches(user_code_m, user_len_m);
					entry_len = 0;
					if (!ok) begin
						ev = EV_NAME_BAD;
					end else if (alarm_m) begin
						ev = EV_LOCKED;
					end else begin
						lock_phase = PH_PASS;
						ev = EV_NAME_OK;
					end
				end else begin
					ev = edit_entry(k);
				end
			end
		endcase
		return '{lock_phase, ev, 3'(entry_len), fail_cnt, fan_m, light_m, alarm_m};
	endfunction

	function automatic int unsigned pick_gap(input bit calm);
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] rand_code_char();
		int unsigned v;
		v = $urandom_range(0, 13);
		case (v)
			10: return KEY_PLUS;
			11: return KEY_MINUS;
			12: return KEY_SLASH;
			13: return KEY_STAR;
			default: return KEY_0 + 8'(v);
		endcase
	endfunction

	function automatic logic [7:0] other_char(input logic [7:0] c);
		logic [7:0] k;
		do k = rand_code_char(); while (k == c);
		return k;
	endfunction

	function automatic logic [47:0] rand_code();
		logic [47:0] code;
		for (int i = 0; i < CODE_BYTES; i++)
			code[8*i +: 8] = rand_code_char();
		return code;
	endfunction

	function automatic logic [7:0] noise_key();
		case ($urandom_range(0, 5))
			0, 1: return 8'($urandom_range(0, 255));
			2: return KEY_E;
			3: return KEY_C;
			default: return rand_code_char();
		endcase
	endfunction

	task automatic flag_error(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $realtime, what);
	endtask

	task automatic send_key(input logic [7:0] k);
		int unsigned gap;
		// Outside the lockout test a failing password that reaches the trial limit would latch the alarm for good,
		// so the entry is corrected to the right password before the check goes out.
		if (!lockout_ok && k == KEY_E && lock_phase == PH_PASS &&
				!entry_matches(pass_code_m, pass_len_m) &&
				int'(fail_cnt) + 1 >= int'(trials_m)) begin
			while (entry_len != 0)
				send_key(KEY_C);
			for (int i = 0; i < pass_len_m; i++)
				send_key(pass_code_m[8*i +: 8]);
		end
		gap = pick_gap(tx_calm);
		if (gap != 0) begin
			key_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		key_if.valid <= 1'b1;
		key_if.key <= k;
		pending_status.push_back(step_lock(k));
		keys_sent++;
		do @(posedge clk); while (key_if.ready !== 1'b1);
	endtask

	task automatic wait_idle();
		key_if.valid <= 1'b0;
		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [47:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= value;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		cfg_if.valid <= 1'b0;
		case (idx)
			CFG_USER_CODE:   user_code_m = value;
			CFG_USER_LENGTH: user_len_m = value[2:0];
			CFG_PASS_CODE:   pass_code_m = value;
			CFG_PASS_LENGTH: pass_len_m = value[2:0];
			CFG_MAX_TRIALS:  trials_m = value[7:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(input logic [47:0] ucode, input logic [2:0] ulen,
			input logic [47:0] pcode, input logic [2:0] plen, input logic [7:0] trials);
		write_reg(CFG_USER_CODE, ucode);
		write_reg(CFG_USER_LENGTH, 48'(ulen));
		write_reg(CFG_PASS_CODE, pcode);
		write_reg(CFG_PASS_LENGTH, 48'(plen));
		write_reg(CFG_MAX_TRIALS, 48'(trials));
	endtask

	task automatic type_code(input logic [47:0] code, input logic [2:0] len, input bit bad);
		int unsigned n;
		int unsigned slip;
		logic [7:0]  k;
		n = (len == 3'd0 || len > CODE_BYTES) ? $urandom_range(1, CODE_BYTES) : len;
		slip = n;
		if (bad) begin
			case ($urandom_range(0, 2))
				0: slip = $urandom_range(0, n - 1);
				1: begin
					if (n < CODE_BYTES)
						n++;
					else
						n--;
				end
				default: n--;
			endcase
		end
		for (int i = 0; i < n; i++) begin
			k = (i == slip || i >= len) ? other_char(code[8*i +: 8]) : code[8*i +: 8];
			if ($urandom_range(0, 99) < 12) begin
				send_key(rand_code_char());
				send_key(KEY_C);
			end
			send_key(k);
		end
		send_key(KEY_E);
	endtask

	task automatic run_sessions(input int unsigned count, input int unsigned pass_ok_pct);
		int unsigned stop_at;
		int unsigned steps;
		stop_at = keys_sent + count;
		while (keys_sent < stop_at) begin
			if ($urandom_range(0, 99) < 70) begin
				type_code(user_code_m, user_len_m, $urandom_range(0, 99) < 20);
				if (lock_phase == PH_PASS)
					type_code(pass_code_m, pass_len_m, $urandom_range(0, 99) >= pass_ok_pct);
				if (lock_phase == PH_CTRL) begin
					steps = $urandom_range(1, 6);
					repeat (steps) begin
						case ($urandom_range(0, 5))
							0: send_key(KEY_5);
							1: send_key(KEY_6);
							2: send_key(KEY_8);
							3: send_key(KEY_9);
							default: send_key(noise_key());
						endcase
					end
					if ($urandom_range(0, 9) != 0)
						send_key(KEY_C);
				end
			end else begin
				steps = $urandom_range(1, 8);
				repeat (steps) send_key(noise_key());
			end
		end
	endtask

	task automatic test_directed_defaults();
		send_key(8'h00);
		send_key(8'hFF);
		send_key(KEY_C);
		send_key(KEY_PLUS);
		send_key(KEY_MINUS);
		send_key(KEY_SLASH);
		send_key(KEY_STAR);
		send_key(KEY_0);
		send_key(KEY_9);
		send_key(KEY_0 + 8'd1);
		send_key(KEY_C);
		send_key(KEY_E);
		type_code(user_code_m, user_len_m, 1'b0);
		send_key(KEY_E);
		type_code(pass_code_m, pass_len_m, 1'b0);
		send_key(KEY_5);
		send_key(KEY_8);
		send_key(KEY_E);
		send_key(KEY_9);
		send_key(KEY_C);
		wait_idle();
	endtask

	task automatic test_output_backpressure();
		hold_cycles = 300;
		run_sessions(420, 70);
		wait_idle();
	endtask

	task automatic test_short_name_long_pass();
		set_config(rand_code(), 3'd1, rand_code(), 3'd6, 8'd255);
		tx_calm = 1'b1;
		rx_calm = 1'b1;
		run_sessions(200, 50);
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		run_sessions(200, 50);
		wait_idle();
	endtask

	task automatic test_bad_lengths();
		set_config(48'h0, 3'd0, rand_code(), 3'd5, 8'd255);
		run_sessions(60, 70);
		wait_idle();
		write_reg(CFG_USER_CODE, 48'hFFFF_FFFF_FFFF);
		write_reg(CFG_USER_LENGTH, 48'd7);
		run_sessions(40, 70);
		wait_idle();
		set_config(rand_code(), 3'd2, rand_code(), 3'd0, 8'd255);
		run_sessions(60, 70);
		wait_idle();
		write_reg(CFG_PASS_LENGTH, 48'd7);
		run_sessions(60, 70);
		wait_idle();
	endtask

	task automatic test_long_name_short_pass();
		set_config(rand_code(), 3'd6, {40'hFF_FFFF_FFFF, rand_code_char()}, 3'd1, 8'd1);
		run_sessions(400, 60);
		wait_idle();
	endtask

	task automatic test_lockout();
		set_config(rand_code(), 3'd4, rand_code(), 3'd3, 8'd3);
		lockout_ok = 1'b1;
		run_sessions(350, 40);
		wait_idle();
		write_reg(CFG_MAX_TRIALS, 48'd0);
		run_sessions(100, 40);
		wait_idle();
	endtask

	always @(posedge clk) begin
		if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
			if (pending_status.size() == 0) begin
				flag_error("status word arrived with nothing expected");
			end else begin
				want = pending_status.pop_front();
				if (res_if.phase !== want.phase || res_if.event_res !== want.ev ||
						res_if.entry_count !== want.count || res_if.failures !== want.failures ||
						res_if.fan_on !== want.fan || res_if.light_on !== want.light ||
						res_if.alarm_on !== want.alarm)
					flag_error($sformatf({"status mismatch: got phase %0d ev %0d count %0d ",
						"fail %0d fan %b light %b alarm %b, expected phase %0d ev %0d ",
						"count %0d fail %0d fan %b light %b alarm %b"},
						res_if.phase, res_if.event_res, res_if.entry_count, res_if.failures,
						res_if.fan_on, res_if.light_on, res_if.alarm_on,
						want.phase, want.ev, want.count, want.failures,
						want.fan, want.light, want.alarm));
			end
		end
	end

	initial begin
		int unsigned stall;
		stall = 0;
		res_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_cycles != 0) begin
				res_if.ready <= 1'b0;
				hold_cycles--;
			end else if (stall != 0) begin
				res_if.ready <= 1'b0;
				stall--;
			end else begin
				res_if.ready <= 1'b1;
				if (!rx_calm && $urandom_range(0, 99) < 25)
					stall = pick_gap(1'b0);
			end
		end
	end

	initial begin
		#(64'd10_000_000);
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		key_if.valid <= 1'b0;
		key_if.key <= 8'h00;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= CFG_USER_CODE;
		cfg_if.data <= 48'h0;
		user_code_m = USER_CODE_RST;
		user_len_m = USER_LENGTH_RST;
		pass_code_m = PASS_CODE_RST;
		pass_len_m = PASS_LENGTH_RST;
		trials_m = MAX_TRIALS_RST;
		lock_phase = PH_USER;
		entry_len = 0;
		fail_cnt = 8'd0;
		fan_m = 1'b0;
		light_m = 1'b0;
		alarm_m = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_defaults();
		test_output_backpressure();
		test_short_name_long_pass();
		test_bad_lengths();
		test_long_name_short_pass();
		test_lockout();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
